### sv/olm_pkg.sv
// shared types and constants for the operation latency monitor
package olm_pkg;

   localparam int TAG_WIDTH_DEFAULT = 16;
   localparam int TAG_FIELD_W       = 16;
   localparam int TIME_W            = 32;
   localparam int CFG_W             = 10;
   localparam int DIV_STEPS         = TIME_W;
   localparam int STEP_CNT_W        = $clog2(DIV_STEPS);

   localparam logic [CFG_W-1:0] CYCLES_PER_US_RESET = CFG_W'(240);

   // opcodes of an input transaction
   localparam logic [1:0] OP_BEGIN  = 2'd0;
   localparam logic [1:0] OP_END    = 2'd1;
   localparam logic [1:0] OP_REPORT = 2'd2;

   // which report statistic goes through the divider
   localparam logic [1:0] SEL_TOTAL = 2'd0;
   localparam logic [1:0] SEL_WORST = 2'd1;
   localparam logic [1:0] SEL_WAIT  = 2'd2;

   typedef struct packed {
      logic [1:0]             opcode;
      logic [TIME_W-1:0]      request_time;
      logic [TIME_W-1:0]      event_time;
      logic [TAG_FIELD_W-1:0] task_tag;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0]      operation_count;
      logic [TIME_W-1:0]      total_us;
      logic [TIME_W-1:0]      worst_us;
      logic [TAG_FIELD_W-1:0] worst_task;
      logic [TIME_W-1:0]      worst_wait_us;
      logic [TAG_FIELD_W-1:0] worst_wait_task;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic       upd_begin;
      logic       upd_end;
      logic       snap;
      logic       div_start;
      logic [1:0] div_sel;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       div_busy;
      logic       div_done;
   } status_type;

endpackage

### sv/olm_div.sv
// restoring divider, one quotient bit per cycle
module olm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [olm_pkg::TIME_W-1:0] dividend,
   input  logic [olm_pkg::CFG_W-1:0]  divisor,
   output logic                       busy,
   output logic                       done,
   output logic [olm_pkg::TIME_W-1:0] quotient
);
   import olm_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CFG_W-1:0]      rem_ff, rem_in;
   logic [CFG_W-1:0]      dvs_ff, dvs_in;
   logic [TIME_W-1:0]     quo_ff, quo_in;
   logic [CFG_W:0]        trial;
   logic [CFG_W:0]        diff;

   assign trial = {rem_ff, quo_ff[TIME_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // quotient bits shift in where the dividend bits shift out
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[CFG_W-1:0];
            quo_in = {quo_ff[TIME_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CFG_W-1:0];
            quo_in = {quo_ff[TIME_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### sv/olm_dp.sv
// datapath: statistics registers, report snapshot, divider and output register
module olm_dp #(
   parameter int TAG_WIDTH = olm_pkg::TAG_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  olm_pkg::req_type          req_payload,
   input  logic                      csr_wr_en,
   input  logic [olm_pkg::CFG_W-1:0] csr_wr_data,
   input  olm_pkg::cmd_type          cmd,
   output olm_pkg::status_type       status,
   output olm_pkg::rsp_type          rsp_payload
);
   import olm_pkg::*;

   localparam int TagBits = (TAG_WIDTH < TAG_FIELD_W) ? TAG_WIDTH : TAG_FIELD_W;

   logic [CFG_W-1:0]   cpu_ff;
   logic [TIME_W-1:0]  grant_time_ff;
   logic [TagBits-1:0] current_task_ff;
   logic [TIME_W-1:0]  op_count_ff;
   logic [TIME_W-1:0]  total_cycles_ff;
   logic [TIME_W-1:0]  worst_cycles_ff;
   logic [TagBits-1:0] worst_owner_ff;
   logic [TIME_W-1:0]  worst_wait_ff;
   logic [TagBits-1:0] worst_wait_owner_ff;

   // report snapshot, cycle values are replaced by their quotients in place
   logic [TIME_W-1:0]  snap_count_ff;
   logic [TIME_W-1:0]  snap_total_ff;
   logic [TIME_W-1:0]  snap_worst_ff;
   logic [TagBits-1:0] snap_worst_task_ff;
   logic [TIME_W-1:0]  snap_wait_ff;
   logic [TagBits-1:0] snap_wait_task_ff;
   logic [CFG_W-1:0]   snap_div_ff;

   rsp_type            rsp_ff;

   logic [TagBits-1:0] tag;
   logic [TIME_W-1:0]  wait_cycles;
   logic [TIME_W-1:0]  dur_cycles;
   logic [TIME_W-1:0]  dividend;
   logic [TIME_W-1:0]  quotient;
   logic               div_busy;
   logic               div_done;

   assign tag         = req_payload.task_tag[TagBits-1:0];
   assign wait_cycles = req_payload.event_time - req_payload.request_time;
   assign dur_cycles  = req_payload.event_time - grant_time_ff;

   always_comb begin
      case (cmd.div_sel)
         SEL_TOTAL: dividend = snap_total_ff;
         SEL_WORST: dividend = snap_worst_ff;
         default:   dividend = snap_wait_ff;
      endcase
   end

   olm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (snap_div_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_ff              <= CYCLES_PER_US_RESET;
         grant_time_ff       <= '0;
         current_task_ff     <= '0;
         op_count_ff         <= '0;
         total_cycles_ff     <= '0;
         worst_cycles_ff     <= '0;
         worst_owner_ff      <= '0;
         worst_wait_ff       <= '0;
         worst_wait_owner_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            cpu_ff <= csr_wr_data;
         end
         if (cmd.upd_begin) begin
            grant_time_ff   <= req_payload.event_time;
            current_task_ff <= tag;
            if (wait_cycles > worst_wait_ff) begin
               worst_wait_ff       <= wait_cycles;
               worst_wait_owner_ff <= tag;
            end
         end
         if (cmd.upd_end) begin
            op_count_ff     <= op_count_ff + 1'b1;
            total_cycles_ff <= total_cycles_ff + dur_cycles;
            if (dur_cycles > worst_cycles_ff) begin
               worst_cycles_ff <= dur_cycles;
               worst_owner_ff  <= current_task_ff;
            end
         end
         if (cmd.snap) begin
            op_count_ff         <= '0;
            total_cycles_ff     <= '0;
            worst_cycles_ff     <= '0;
            worst_owner_ff      <= '0;
            worst_wait_ff       <= '0;
            worst_wait_owner_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         snap_count_ff      <= op_count_ff;
         snap_total_ff      <= total_cycles_ff;
         snap_worst_ff      <= worst_cycles_ff;
         snap_worst_task_ff <= worst_owner_ff;
         snap_wait_ff       <= worst_wait_ff;
         snap_wait_task_ff  <= worst_wait_owner_ff;
         // zero divisor acts as one
         snap_div_ff        <= (cpu_ff == '0) ? CFG_W'(1) : cpu_ff;
      end else if (div_done) begin
         case (cmd.div_sel)
            SEL_TOTAL: snap_total_ff <= quotient;
            SEL_WORST: snap_worst_ff <= quotient;
            default:   snap_wait_ff  <= quotient;
         endcase
      end
      if (cmd.load_out) begin
         rsp_ff.operation_count <= snap_count_ff;
         rsp_ff.total_us        <= snap_total_ff;
         rsp_ff.worst_us        <= snap_worst_ff;
         rsp_ff.worst_task      <= TAG_FIELD_W'(snap_worst_task_ff);
         rsp_ff.worst_wait_us   <= snap_wait_ff;
         rsp_ff.worst_wait_task <= TAG_FIELD_W'(snap_wait_task_ff);
      end
   end

   assign status.opcode   = req_payload.opcode;
   assign status.div_busy = div_busy;
   assign status.div_done = div_done;
   assign rsp_payload     = rsp_ff;

endmodule

### sv/olm_ctrl.sv
// controller: transaction decode, divider sequencing and result valid
module olm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  olm_pkg::status_type status,
   output olm_pkg::cmd_type    cmd
);
   import olm_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.div_sel   = sel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (status.opcode)
                  OP_BEGIN: cmd.upd_begin = 1'b1;
                  OP_END:   cmd.upd_end   = 1'b1;
                  OP_REPORT: begin
                     cmd.snap = 1'b1;
                     sel_in   = SEL_TOTAL;
                     state_in = ST_START;
                  end
                  default: ;
               endcase
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.div_done) begin
               if (sel_ff == SEL_WAIT) begin
                  state_in = ST_WRITE;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  state_in = ST_START;
               end
            end
         end
         ST_WRITE: begin
            // hold until the previous result has been taken
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SEL_TOTAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/operation_latency_monitor_unit.sv
// top level of the operation latency monitor
// begin, end and unused-opcode transactions: taken while idle, the input stays ready
// report: the input stays closed while the one-bit-per-cycle divider runs three times in turn;
//   it opens again in the same cycle as result valid, once the output register is free
// a finished result waits in the output register while new transactions are taken
// reset (synchronous, active high) clears all statistics and sets cycles_per_us to 240
module operation_latency_monitor_unit #(
   parameter int TAG_WIDTH = olm_pkg::TAG_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  olm_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output olm_pkg::rsp_type          rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [olm_pkg::CFG_W-1:0] csr_wr_data
);
   import olm_pkg::*;

   cmd_type    cmd;
   status_type status;

   olm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   olm_dp #(
      .TAG_WIDTH (TAG_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   // a result is never written over one that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("result register loaded while a result is pending");

   // no transaction is taken while the divider runs
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> !req_ready)
      else $error("transaction taken while divider busy");

   // an accepted report closes the input until its result is built
   a_report_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_payload.opcode == OP_REPORT) |=> !req_ready)
      else $error("input open right after a report");

endmodule

### dv/operation_latency_monitor_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the operation latency monitor unit
module operation_latency_monitor_unit_tb;
   import olm_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         SETTLE      = 150;
   localparam int         CYCLE_LIMIT = 1_000_000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_wr_en = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   // expected reports and pending transactions
   rsp_type report_q[$];
   req_type pending_q[$];

   // predicted block state
   logic [CFG_W-1:0]       us_divisor = CYCLES_PER_US_RESET;
   logic [TIME_W-1:0]      grant_mark = '0;
   logic [TAG_FIELD_W-1:0] owner_tag = '0;
   logic [TIME_W-1:0]      ended_ops = '0;
   logic [TIME_W-1:0]      busy_total = '0;
   logic [TIME_W-1:0]      longest_op = '0;
   logic [TAG_FIELD_W-1:0] longest_op_tag = '0;
   logic [TIME_W-1:0]      longest_wait = '0;
   logic [TAG_FIELD_W-1:0] longest_wait_tag = '0;

   // stimulus generator state
   logic [TIME_W-1:0] gen_grant = '0;
   logic [TIME_W-1:0] last_span = '0;

   int     send_idle_pct = 0;
   int     stall_pct = 0;
   int     hold_off_len = 0;
   int     stall_left = 0;
   bit     req_took = 1'b0;
   int     fail_cnt = 0;
   int     sent_cnt = 0;
   int     reports_checked = 0;
   int     rate_writes = 0;
   longint cycle_cnt = 0;
   rsp_type got_rsp;
   rsp_type want_rsp;

   operation_latency_monitor_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [TIME_W-1:0] in_us(input logic [TIME_W-1:0] cycles);
      logic [TIME_W-1:0] div;
      div = (us_divisor == '0) ? TIME_W'(1) : TIME_W'(us_divisor);
      return cycles / div;
   endfunction

   task automatic apply_event(input req_type ev);
      logic [TIME_W-1:0] span;
      rsp_type rep;
      case (ev.opcode)
         OP_BEGIN: begin
            span = ev.event_time - ev.request_time;
            owner_tag = ev.task_tag;
            grant_mark = ev.event_time;
            if (span > longest_wait) begin
               longest_wait = span;
               longest_wait_tag = ev.task_tag;
            end
         end
         OP_END: begin
            span = ev.event_time - grant_mark;
            ended_ops = ended_ops + 1;
            busy_total = busy_total + span;
            if (span > longest_op) begin
               longest_op = span;
               longest_op_tag = owner_tag;
            end
         end
         OP_REPORT: begin
            rep.operation_count = ended_ops;
            rep.total_us = in_us(busy_total);
            rep.worst_us = in_us(longest_op);
            rep.worst_task = longest_op_tag;
            rep.worst_wait_us = in_us(longest_wait);
            rep.worst_wait_task = longest_wait_tag;
            report_q.push_back(rep);
            // grant time and current task survive the clear
            ended_ops = '0;
            busy_total = '0;
            longest_op = '0;
            longest_op_tag = '0;
            longest_wait = '0;
            longest_wait_tag = '0;
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
      if (want !== got) begin
         fail_cnt++;
         if (fail_cnt <= 10)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // driver: new transaction offered at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         req_took = 1'b0;
         if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // accepted transactions go through the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         req_took = 1'b1;
         sent_cnt++;
         apply_event(req_payload);
      end
   end

   // receiver with random stalls and an optional long hold-off
   always @(negedge clock) begin
      if (hold_off_len > 0) begin
         stall_left = hold_off_len;
         hold_off_len = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_rsp = rsp_payload;
         if (report_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= 10)
               $display("unexpected report: count %0d total_us %0d",
                        got_rsp.operation_count, got_rsp.total_us);
         end else begin
            want_rsp = report_q.pop_front();
            reports_checked++;
            check_field("operation_count", want_rsp.operation_count,
                        got_rsp.operation_count);
            check_field("total_us", want_rsp.total_us, got_rsp.total_us);
            check_field("worst_us", want_rsp.worst_us, got_rsp.worst_us);
            check_field("worst_task", TIME_W'(want_rsp.worst_task),
                        TIME_W'(got_rsp.worst_task));
            check_field("worst_wait_us", want_rsp.worst_wait_us, got_rsp.worst_wait_us);
            check_field("worst_wait_task", TIME_W'(want_rsp.worst_wait_task),
                        TIME_W'(got_rsp.worst_wait_task));
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding",
                  cycle_cnt, report_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic push_item(input logic [1:0] op, input logic [TIME_W-1:0] req_t,
                            input logic [TIME_W-1:0] evt_t,
                            input logic [TAG_FIELD_W-1:0] tag);
      req_type it;
      it.opcode = op;
      it.request_time = req_t;
      it.event_time = evt_t;
      it.task_tag = tag;
      pending_q.push_back(it);
   endtask

   function automatic logic [TIME_W-1:0] pick_span();
      logic [TIME_W-1:0] s;
      case ($urandom_range(4))
         0: s = $urandom_range(0, 3000);
         1: s = $urandom_range(0, 1_000_000);
         2: s = $urandom;
         3: s = last_span; // repeat a span to hit ties
         default: s = 32'hFFFF_FFFF - $urandom_range(0, 1000);
      endcase
      last_span = s;
      return s;
   endfunction

   function automatic logic [TAG_FIELD_W-1:0] pick_tag();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return TAG_FIELD_W'($urandom);
      endcase
   endfunction

   task automatic push_begin();
      logic [TIME_W-1:0] req_t;
      req_t = $urandom;
      gen_grant = req_t + pick_span();
      push_item(OP_BEGIN, req_t, gen_grant, pick_tag());
   endtask

   task automatic push_end();
      push_item(OP_END, $urandom, gen_grant + pick_span(), TAG_FIELD_W'($urandom));
   endtask

   // mostly begin/end sequences, some lone events, reports and unused opcodes
   task automatic add_traffic(input int n, input int report_pct);
      int made;
      int pick;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            push_begin();
            made++;
            repeat ($urandom_range(1, 3)) begin
               push_end();
               made++;
            end
            if ($urandom_range(99) < report_pct) begin
               push_item(OP_REPORT, $urandom, $urandom, TAG_FIELD_W'($urandom));
               made++;
            end
         end else if (pick < 80) begin
            push_end();
            made++;
         end else if (pick < 88) begin
            push_item(OP_REPORT, $urandom, $urandom, TAG_FIELD_W'($urandom));
            made++;
         end else if (pick < 94) begin
            push_item(OP_UNUSED, $urandom, $urandom, TAG_FIELD_W'($urandom));
         end else begin
            push_begin();
            made++;
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_q.size() != 0 || req_valid || report_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_rate(input logic [CFG_W-1:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      us_divisor = v;
      rate_writes++;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset divisor, wraps, ties, missing begin, clear behavior
      push_item(OP_REPORT, '0, '0, '0);
      push_item(OP_END, '0, 32'hFFFF_FFFF, '0);
      push_item(OP_UNUSED, '1, '1, '1);
      push_item(OP_REPORT, '1, '1, '1);
      push_item(OP_BEGIN, 32'hFFFF_FFFF, 32'd0, 16'hFFFF);
      push_item(OP_BEGIN, 32'd5, 32'd6, 16'h1234);
      push_item(OP_BEGIN, 32'd0, 32'hFFFF_FFFF, 16'h0000);
      push_item(OP_BEGIN, 32'd100, 32'd100, 16'hABCD);
      push_item(OP_END, '0, 32'd580, '0);
      push_item(OP_END, '0, 32'd580, '1);
      push_item(OP_END, '0, 32'd99, '0);
      push_item(OP_REPORT, '0, '0, '0);
      push_item(OP_END, '0, 32'd340, '0);
      push_item(OP_REPORT, '0, '0, '0);
      push_item(OP_UNUSED, '0, '0, '0);
      push_item(OP_BEGIN, '0, '0, '0);
      push_item(OP_END, '0, '0, '0);
      push_item(OP_REPORT, '0, '0, '0);
      wait_idle();

      write_rate(10'd1023);
      add_traffic(200, 25);
      wait_idle();

      write_rate(10'd1);
      send_idle_pct = 77;
      add_traffic(200, 25);
      wait_idle();

      // a divisor of zero acts as one
      write_rate(10'd0);
      send_idle_pct = 0;
      stall_pct = 77;
      add_traffic(200, 25);
      wait_idle();

      write_rate(CFG_W'($urandom_range(2, 1022)));
      send_idle_pct = 35;
      stall_pct = 35;
      add_traffic(200, 25);
      wait_idle();

      // long receiver hold-off while reports pile up and back-pressure the input
      write_rate(CFG_W'($urandom_range(1, 8)));
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_len = 1500;
      repeat (3) push_item(OP_REPORT, $urandom, $urandom, TAG_FIELD_W'($urandom));
      add_traffic(150, 30);
      wait_idle();
      stall_pct = 77;
      add_traffic(50, 25);
      wait_idle();

      write_rate(CYCLES_PER_US_RESET);
      send_idle_pct = 35;
      stall_pct = 0;
      add_traffic(100, 25);
      wait_idle();

      if (report_q.size() != 0) begin
         fail_cnt += report_q.size();
         $display("%0d expected reports never arrived", report_q.size());
      end
      $display("covered %0d transactions and %0d checked reports over %0d rate settings",
               sent_cnt, reports_checked, rate_writes + 1);
      $display("mismatches or missing/extra reports: %0d", fail_cnt);
      if (fail_cnt == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
sv/olm_pkg.sv
sv/olm_div.sv
sv/olm_dp.sv
sv/olm_ctrl.sv
sv/operation_latency_monitor_unit.sv
dv/operation_latency_monitor_unit_tb.sv
